>>> rtl/core/dts_pkg.sv
package dts_pkg;

    // Width of the operands of the shared signed multiplier.
    localparam int MUL_W = 35;

    // Iterative divider: dividend and divisor widths.
    localparam int DIV_NW = 46;
    localparam int DIV_DW = 24;

    // Iterative square root: radicand width and root width.
    localparam int SQ_W = 63;
    localparam int ROOT_W = 31;

    // Base of 0.177 + 0.000823 * h_ft in Q20, and the altitude slope.
    localparam logic [26:0] TMP_BASE_Q20 = 27'd185598;
    localparam logic [23:0] ALT_COEF = 24'd11596976;

    // ceil(2^35 / 10): exact division by ten for operands below 2^25.
    localparam logic [31:0] RECIP10 = 32'd3435973837;

    // One in Q30.
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Configuration register indexes.
    localparam logic CFG_MEAN_WIND = 1'b0;
    localparam logic CFG_MIN_ALT = 1'b1;

endpackage

>>> rtl/core/dryden_turbulence_step.sv
// Low-altitude Dryden gust generator, one step of the three gust filters per word.
//
// The slave channel takes one word per simulation step: airspeed, altitude, step
// length and three standard-normal samples. The master channel returns the new
// longitudinal, lateral and vertical gust velocities. The user writes mean wind
// speed and altitude floor via the configuration port only while idle (unenforced).
//
// Each step runs the fifth-root search (22 bits, each through states R1 to R4 and
// the shared multiplier), then the divider for the lateral intensity and the
// square root for the vertical update. Every product goes through one registered
// multiplier under the sequencer. s_axis_tready is high only while idle, so the
// next word can be taken, at the earliest, in the cycle after the result has
// been taken.
//
// Reset clears the gust states to zero, sets mean wind to zero and the altitude
// floor to one metre. If the receiver stalls, the result is held on m_axis_tdata
// and no new word is accepted until it is taken.
module dryden_turbulence_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // airspeed[15:0], altitude[39:16], time_step[59:40],
    // noise_lon[75:60], noise_lat[91:76], noise_ver[107:92], zero pad
    input  logic [111:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // gust_lon[31:0], gust_lat[63:32], gust_ver[95:64]
    output logic [95:0]   m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [22:0]   i_cfg_data
);

    localparam int MW = dts_pkg::MUL_W;
    localparam int PW = 2 * dts_pkg::MUL_W;

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_VD   = 5'd1;
    localparam logic [4:0] ST_T0   = 5'd2;
    localparam logic [4:0] ST_T1   = 5'd3;
    localparam logic [4:0] ST_SW   = 5'd4;
    localparam logic [4:0] ST_R1   = 5'd5;
    localparam logic [4:0] ST_R2   = 5'd6;
    localparam logic [4:0] ST_R3   = 5'd7;
    localparam logic [4:0] ST_R4   = 5'd8;
    localparam logic [4:0] ST_S0   = 5'd9;
    localparam logic [4:0] ST_C1   = 5'd10;
    localparam logic [4:0] ST_C2   = 5'd11;
    localparam logic [4:0] ST_C3   = 5'd12;
    localparam logic [4:0] ST_RU   = 5'd13;
    localparam logic [4:0] ST_RU2  = 5'd14;
    localparam logic [4:0] ST_W1   = 5'd15;
    localparam logic [4:0] ST_W2   = 5'd16;
    localparam logic [4:0] ST_MB   = 5'd17;
    localparam logic [4:0] ST_MC   = 5'd18;
    localparam logic [4:0] ST_MD   = 5'd19;
    localparam logic [4:0] ST_ME   = 5'd20;
    localparam logic [4:0] ST_MF   = 5'd21;
    localparam logic [4:0] ST_MG   = 5'd22;
    localparam logic [4:0] ST_MH   = 5'd23;
    localparam logic [4:0] ST_MI   = 5'd24;
    localparam logic [4:0] ST_OUT  = 5'd25;

    logic [4:0]          r_state, n_state;

    // Configuration.
    logic [15:0]         r_msw;
    logic [22:0]         r_minalt;

    // Captured input word.
    logic [15:0]         r_v;
    logic signed [23:0]  r_alt;
    logic [19:0]         r_dt;
    logic signed [15:0]  r_nlon, r_nlat, r_nver;

    // Intermediate values of one step.
    logic [22:0]         r_h;
    logic [26:0]         r_t;
    logic [20:0]         r_sw;
    logic [21:0]         r_q, r_cand;
    logic [4:0]          r_bit;
    logic [23:0]         r_s;
    logic [31:0]         r_c;
    logic [30:0]         r_rw, r_ruv;
    logic                r_big;
    logic [21:0]         r_suv;
    logic [30:0]         r_kuv, r_kw;
    logic [22:0]         r_nuv, r_nw;
    logic signed [32:0]  r_dec;

    // Gust states, which are also the result word.
    logic signed [31:0]  r_glon, r_glat, r_gver;

    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] prod;

    logic                              div_start, div_busy;
    logic [dts_pkg::DIV_NW-1:0]        div_num, div_quo;
    logic [dts_pkg::DIV_DW-1:0]        div_den;
    logic                              sq_start, sq_busy;
    logic [dts_pkg::SQ_W-1:0]          sq_x;
    logic [dts_pkg::ROOT_W-1:0]        sq_root;

    logic [22:0]         minalt;
    logic [22:0]         h_now;
    logic [21:0]         cand;
    logic [45:0]         ruv_pre;
    logic [30:0]         ruv_now;
    logic signed [33:0]  kick;
    logic signed [31:0]  g_new;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] y;
        if (x > 35'sd2147483647) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < -35'sd2147483648) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    dts_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    dts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    dts_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_x     (sq_x),
        .o_busy  (sq_busy),
        .o_root  (sq_root)
    );

    // An altitude floor of zero acts as the smallest step, so h never becomes zero.
    assign minalt = (r_minalt == '0) ? 23'd1 : r_minalt;
    assign h_now = (r_alt[23] || (r_alt[22:0] < minalt)) ? minalt : r_alt[22:0];

    // Next candidate of the fifth-root search.
    assign cand = r_q | (22'd1 << r_bit);

    // Above 2^34 the lateral rate saturates through the clamped product c * 2^14.
    assign ruv_pre = r_big ? {r_c, 14'd0} : prod[65:20];
    assign ruv_now = (ruv_pre > 46'(dts_pkg::ONE_Q30)) ? dts_pkg::ONE_Q30 : ruv_pre[30:0];

    // Noise kick and the new gust value from the stored decay term.
    assign kick = prod[45:12];
    assign g_new = sat32(35'(r_dec) + 35'(kick));

    // Operands of the shared multiplier for each step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_VD: begin
                mul_a = MW'(r_v);
                mul_b = MW'(r_dt);
            end
            ST_T0: begin
                mul_a = MW'(r_h);
                mul_b = MW'(dts_pkg::ALT_COEF);
            end
            ST_T1: begin
                mul_a = MW'({r_msw, 8'd0} + 24'd5);
                mul_b = MW'(dts_pkg::RECIP10);
            end
            ST_R1: begin
                mul_a = MW'(cand);
                mul_b = MW'(cand);
            end
            ST_R2: begin
                mul_a = MW'(prod[43:20]);
                mul_b = MW'(prod[43:20]);
            end
            ST_R3: begin
                mul_a = MW'(prod[47:20]);
                mul_b = MW'(r_cand);
            end
            ST_S0: begin
                mul_a = MW'(r_q);
                mul_b = MW'(r_q);
            end
            ST_C1: begin
                mul_a = MW'(prod[43:20]);
                mul_b = MW'(prod[43:20]);
            end
            ST_C2: begin
                mul_a = MW'(prod[47:20]);
                mul_b = MW'(r_s);
            end
            ST_RU: begin
                mul_a = MW'(div_quo[33:0]);
                mul_b = MW'(r_c);
            end
            ST_W2: begin
                mul_a = MW'(r_kuv);
                mul_b = MW'(r_suv);
            end
            ST_MB: begin
                mul_a = MW'(r_kw);
                mul_b = MW'(r_sw);
            end
            ST_MC: begin
                mul_a = MW'(r_glon);
                mul_b = MW'(dts_pkg::ONE_Q30 - r_ruv);
            end
            ST_MD: begin
                mul_a = MW'(r_nuv);
                mul_b = MW'(r_nlon);
            end
            ST_ME: begin
                mul_a = MW'(r_glat);
                mul_b = MW'(dts_pkg::ONE_Q30 - r_ruv);
            end
            ST_MF: begin
                mul_a = MW'(r_nuv);
                mul_b = MW'(r_nlat);
            end
            ST_MG: begin
                mul_a = MW'(r_gver);
                mul_b = MW'(dts_pkg::ONE_Q30 - r_rw);
            end
            ST_MH: begin
                mul_a = MW'(r_nw);
                mul_b = MW'(r_nver);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // The airspeed division starts early and runs beside the root search; the
    // lateral intensity division runs beside the lateral square root.
    always_comb begin
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;
        sq_start = 1'b0;
        sq_x = '0;
        case (r_state)
            ST_T0: begin
                div_start = 1'b1;
                div_num = {prod[35:0], 10'd0};
                div_den = {1'b0, r_h};
            end
            ST_RU2: begin
                div_start = 1'b1;
                div_num = dts_pkg::DIV_NW'({r_sw, 20'd0});
                div_den = r_s;
                sq_start = 1'b1;
                sq_x = {1'b0, ruv_now, 31'd0};
            end
            ST_W1: begin
                if (!div_busy && !sq_busy) begin
                    sq_start = 1'b1;
                    sq_x = {1'b0, r_rw, 31'd0};
                end
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_VD;
            ST_VD:   n_state = ST_T0;
            ST_T0:   n_state = ST_T1;
            ST_T1:   n_state = ST_SW;
            ST_SW:   n_state = ST_R1;
            ST_R1:   n_state = ST_R2;
            ST_R2:   n_state = ST_R3;
            ST_R3:   n_state = ST_R4;
            ST_R4:   n_state = (r_bit == '0) ? ST_S0 : ST_R1;
            ST_S0:   n_state = ST_C1;
            ST_C1:   n_state = ST_C2;
            ST_C2:   n_state = ST_C3;
            ST_C3:   n_state = ST_RU;
            ST_RU:   if (!div_busy) n_state = ST_RU2;
            ST_RU2:  n_state = ST_W1;
            ST_W1:   if (!div_busy && !sq_busy) n_state = ST_W2;
            ST_W2:   if (!sq_busy) n_state = ST_MB;
            ST_MB:   n_state = ST_MC;
            ST_MC:   n_state = ST_MD;
            ST_MD:   n_state = ST_ME;
            ST_ME:   n_state = ST_MF;
            ST_MF:   n_state = ST_MG;
            ST_MG:   n_state = ST_MH;
            ST_MH:   n_state = ST_MI;
            ST_MI:   n_state = ST_OUT;
            ST_OUT:  if (m_axis_tready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and gust states.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_msw <= '0;
            r_minalt <= 23'd256;
            r_glon <= '0;
            r_glat <= '0;
            r_gver <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == dts_pkg::CFG_MEAN_WIND) begin
                    r_msw <= i_cfg_data[15:0];
                end else if (i_cfg_index == dts_pkg::CFG_MIN_ALT) begin
                    r_minalt <= i_cfg_data;
                end
            end
            if (r_state == ST_ME) r_glon <= g_new;
            if (r_state == ST_MG) r_glat <= g_new;
            if (r_state == ST_MI) r_gver <= g_new;
        end
    end

    // Data path registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_v <= s_axis_tdata[15:0];
                r_alt <= s_axis_tdata[39:16];
                r_dt <= s_axis_tdata[59:40];
                r_nlon <= s_axis_tdata[75:60];
                r_nlat <= s_axis_tdata[91:76];
                r_nver <= s_axis_tdata[107:92];
            end
            ST_VD: r_h <= h_now;
            ST_T1: r_t <= dts_pkg::TMP_BASE_Q20 + 27'((prod[46:0] + 47'h8_0000) >> 20);
            ST_SW: begin
                r_sw <= prod[55:35];
                r_q <= '0;
                r_bit <= 5'd21;
            end
            ST_R1: r_cand <= cand;
            ST_R4: begin
                if (prod[49:20] <= 30'(r_t)) r_q <= r_cand;
                if (r_bit != '0) r_bit <= r_bit - 5'd1;
            end
            ST_C1: r_s <= prod[43:20];
            ST_C3: r_c <= prod[51:20];
            ST_RU: begin
                r_rw <= (div_quo > 46'(dts_pkg::ONE_Q30)) ? dts_pkg::ONE_Q30
                                                           : div_quo[30:0];
                r_big <= |div_quo[45:34];
            end
            ST_RU2: r_ruv <= ruv_now;
            ST_W1: begin
                r_suv <= div_quo[21:0];
                r_kuv <= sq_root;
            end
            ST_W2: r_kw <= sq_root;
            ST_MB: r_nuv <= prod[52:30];
            ST_MC: r_nw <= prod[52:30];
            ST_MD: r_dec <= prod[62:30];
            ST_MF: r_dec <= prod[62:30];
            ST_MH: r_dec <= prod[62:30];
            default: begin
                r_dec <= r_dec;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata = {r_gver, r_glat, r_glon};

    // The shared units are never restarted while still working.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_sqrt_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("square root started while busy");

    // Update rates never exceed one, so the decay factor stays non-negative.
    a_rate_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MC) |-> (r_ruv <= dts_pkg::ONE_Q30 && r_rw <= dts_pkg::ONE_Q30))
        else $error("update rate above one");

    // A word taken always starts the sequence, and the result stays until taken.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == ST_VD))
        else $error("accepted word did not start a step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(r_glon)))
        else $error("result dropped while stalled");

endmodule

>>> rtl/core/dts_mul.sv
module dts_mul (
    input  logic                                i_clk,
    input  logic signed [dts_pkg::MUL_W-1:0]    i_a,
    input  logic signed [dts_pkg::MUL_W-1:0]    i_b,
    output logic signed [2*dts_pkg::MUL_W-1:0]  o_p
);

    logic signed [2*dts_pkg::MUL_W-1:0] r_p;

    // The product is registered, so each step of the sequencer sees the last one.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

>>> rtl/core/dts_div.sv
module dts_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dts_pkg::DIV_NW-1:0]    i_num,
    input  logic [dts_pkg::DIV_DW-1:0]    i_den,
    output logic                          o_busy,
    output logic [dts_pkg::DIV_NW-1:0]    o_quo
);

    localparam int CW = $clog2(dts_pkg::DIV_NW + 1);

    logic [CW-1:0]               r_cnt;
    logic [dts_pkg::DIV_DW-1:0]  r_rem;
    logic [dts_pkg::DIV_DW-1:0]  r_den;
    logic [dts_pkg::DIV_NW-1:0]  r_acc;
    logic [dts_pkg::DIV_DW:0]    rem_sh;
    logic [dts_pkg::DIV_DW:0]    diff;
    logic                        ge;

    // Restoring division, one quotient bit a cycle.
    assign rem_sh = {r_rem, r_acc[dts_pkg::DIV_NW-1]};
    assign ge = rem_sh >= {1'b0, r_den};
    assign diff = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(dts_pkg::DIV_NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_acc <= {r_acc[dts_pkg::DIV_NW-2:0], ge};
            r_rem <= ge ? diff[dts_pkg::DIV_DW-1:0] : rem_sh[dts_pkg::DIV_DW-1:0];
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo = r_acc;

endmodule

>>> rtl/core/dts_sqrt.sv
module dts_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dts_pkg::SQ_W-1:0]       i_x,
    output logic                           o_busy,
    output logic [dts_pkg::ROOT_W-1:0]     o_root
);

    localparam logic [dts_pkg::SQ_W-1:0] FIRST_BIT = dts_pkg::SQ_W'(1) << 60;

    logic [dts_pkg::SQ_W-1:0] r_x;
    logic [dts_pkg::SQ_W-1:0] r_res;
    logic [dts_pkg::SQ_W-1:0] r_bit;
    logic [dts_pkg::SQ_W-1:0] trial;
    logic                     ge;

    // Digit-by-digit root: two radicand bits a cycle, one root bit.
    assign trial = r_res + r_bit;
    assign ge = r_x >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_start) begin
            r_bit <= FIRST_BIT;
        end else begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_res <= '0;
        end else if (r_bit != '0) begin
            if (ge) begin
                r_x <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    assign o_busy = (r_bit != '0);
    assign o_root = r_res[dts_pkg::ROOT_W-1:0];

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // airspeed, altitude, time_step, noise_lon, noise_lat, noise_ver
    logic [111:0]  s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // gust_lon, gust_lat, gust_ver
    logic [95:0]   m_axis_tdata;
    logic          i_cfg_we;
    logic          i_cfg_index;
    logic [22:0]   i_cfg_data;

    dryden_turbulence_step dut (.*);

    // One simulation step as the block sees it.
    typedef struct packed {
        logic signed [15:0] n_ver;
        logic signed [15:0] n_lat;
        logic signed [15:0] n_lon;
        logic [19:0]        dt;
        logic signed [23:0] alt;
        logic [15:0]        airspeed;
    } t_step;

    typedef struct packed {
        logic signed [31:0] ver;
        logic signed [31:0] lat;
        logic signed [31:0] lon;
    } t_gusts;

    // A directed row: the step, and optionally the gusts known in advance.
    typedef struct {
        t_step  stim;
        bit     known;
        t_gusts want;
    } t_row;

    // Shadow of the block's state and registers.
    logic [15:0]        mdl_mean_wind;
    logic [22:0]        mdl_min_alt;
    logic signed [31:0] mdl_lon, mdl_lat, mdl_ver;

    t_gusts  gust_queue[$];
    int      fail_count = 0;
    longint  cycle_count = 0;
    int      send_idle_pct, recv_stall_pct;

    localparam longint CYCLE_LIMIT = 64'd2_000_000;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[dryden_turbulence_step] ERROR");
            $finish;
        end
    end

    // Fifth root in Q20 by a bit-by-bit search from the top bit down.
    function automatic logic [63:0] fifth_root(input logic [63:0] t);
        logic [63:0] q, cand, q2, q4, p;
        q = 0;
        for (int b = 21; b >= 0; b--) begin
            cand = q | (64'd1 << b);
            q2 = (cand * cand) >> 20;
            q4 = (q2 * q2) >> 20;
            p = (q4 * cand) >> 20;
            if (p <= t) q = cand;
        end
        return q;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Floor of the signed product shifted right; >>> on a signed value floors.
    function automatic logic signed [31:0] gust_advance(input logic signed [31:0] g,
            input logic [63:0] rate, input logic [63:0] nstd, input logic signed [15:0] n);
        logic signed [127:0] decay, kick, sum;
        decay = 128'(g) * $signed({64'd0, 64'(dts_pkg::ONE_Q30) - rate});
        decay = decay >>> 30;
        kick = $signed({64'd0, nstd}) * 128'(n);
        kick = kick >>> 12;
        sum = decay + kick;
        if (sum > 128'sd2147483647) sum = 128'sd2147483647;
        if (sum < -128'sd2147483648) sum = -128'sd2147483648;
        return sum[31:0];
    endfunction

    // Advances the shadow gust filters by one step and returns the new gusts.
    function automatic t_gusts gust_step(input t_step st);
        logic [63:0] floor_alt, h, t, q, s, c, rwr, rw, ruv, sw, suv, kw, kuv, nw, nuv;
        t_gusts g;
        floor_alt = (mdl_min_alt == 0) ? 64'd1 : 64'(mdl_min_alt);
        h = ($signed(st.alt) < $signed({1'b0, floor_alt[22:0]})) ? floor_alt
                                                                 : 64'(st.alt);
        t = 64'(dts_pkg::TMP_BASE_Q20) + ((h * 64'(dts_pkg::ALT_COEF) + (64'd1 << 19)) >> 20);
        q = fifth_root(t);
        s = (q * q) >> 20;
        c = (((s * s) >> 20) * s) >> 20;
        rwr = ((64'(st.airspeed) * 64'(st.dt)) << 10) / h;
        rw = (rwr > 64'(dts_pkg::ONE_Q30)) ? 64'(dts_pkg::ONE_Q30) : rwr;
        ruv = (((rwr > 64'd17179869184) ? 64'd17179869184 : rwr) * c) >> 20;
        if (ruv > 64'(dts_pkg::ONE_Q30)) ruv = 64'(dts_pkg::ONE_Q30);
        sw = (64'(mdl_mean_wind) * 256 + 5) / 10;
        suv = (sw << 20) / s;
        kw = int_sqrt((2 * rw) << 30);
        kuv = int_sqrt((2 * ruv) << 30);
        nw = (kw * sw) >> 30;
        nuv = (kuv * suv) >> 30;
        mdl_lon = gust_advance(mdl_lon, ruv, nuv, st.n_lon);
        mdl_lat = gust_advance(mdl_lat, ruv, nuv, st.n_lat);
        mdl_ver = gust_advance(mdl_ver, rw, nw, st.n_ver);
        g.lon = mdl_lon;
        g.lat = mdl_lat;
        g.ver = mdl_ver;
        return g;
    endfunction

    function automatic bit ph_ok();
        return fail_count == 0 && gust_queue.size() == 0;
    endfunction

    // Register write; only called while nothing is outstanding.
    task automatic write_reg(input logic idx, input logic [22:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == dts_pkg::CFG_MEAN_WIND) mdl_mean_wind = val[15:0];
        else                               mdl_min_alt = val;
        @(posedge i_clk);
    endtask

    // Sends one word with a random gap ahead of it, then queues its prediction.
    task automatic send_step(input t_step st, input bit known, input t_gusts want);
        t_gusts g;
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {16'd0, st};
        do @(posedge i_clk); while (!s_axis_tready);
        s_axis_tvalid <= 1'b0;
        g = gust_step(st);
        if (known && g !== want) begin
            $error("directed row disagrees with predictor: %h vs %h", want, g);
            fail_count++;
        end
        gust_queue.push_back(known ? want : g);
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        while (gust_queue.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    // Receiver: random stalls, and each taken word checked against the oldest
    // prediction.
    always @(posedge i_clk) begin
        t_gusts got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (gust_queue.size() == 0) begin
                $error("gust word with nothing expected: %h", got);
                fail_count++;
            end else begin
                want = gust_queue.pop_front();
                if (got.lon !== want.lon) begin
                    $error("gust_lon expected %0d got %0d", want.lon, got.lon);
                    fail_count++;
                end
                if (got.lat !== want.lat) begin
                    $error("gust_lat expected %0d got %0d", want.lat, got.lat);
                    fail_count++;
                end
                if (got.ver !== want.ver) begin
                    $error("gust_ver expected %0d got %0d", want.ver, got.ver);
                    fail_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_step rand_step();
        t_step st;
        int mode;
        mode = $urandom_range(9);
        st.airspeed = 16'($urandom);
        st.dt = (mode < 2) ? 20'($urandom_range(1048575, 1)) : 20'($urandom_range(4096, 1));
        // Mostly low realistic altitudes, with some anywhere in the field.
        st.alt = (mode < 3) ? 24'($urandom) : 24'($urandom_range(300000));
        st.n_lon = 16'($urandom);
        st.n_lat = 16'($urandom);
        st.n_ver = 16'($urandom);
        if (mode == 9) st.airspeed = 0;
        return st;
    endfunction

    initial begin
        t_row rows[$];
        t_row r;
        t_gusts zero_g;
        logic [22:0] wind_set[4], alt_set[4];
        t_step st;
        zero_g = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = dts_pkg::CFG_MEAN_WIND;
        i_cfg_data = '0;
        mdl_mean_wind = 0;
        mdl_min_alt = 256;
        mdl_lon = 0;
        mdl_lat = 0;
        mdl_ver = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With the reset mean wind of zero every intensity is zero, so the
        // gusts stay at zero whatever the noise.
        r.known = 1'b1; r.want = zero_g;
        r.stim = '{16'sh7fff, -16'sh8000, 16'sh1234, 20'd1048575, -24'sd8388608, 16'hffff};
        rows.push_back(r);
        r.stim = '{-16'sh8000, 16'sh7fff, 16'sh0, 20'd1, 24'sd8388607, 16'd0};
        rows.push_back(r);
        foreach (rows[i]) send_step(rows[i].stim, rows[i].known, rows[i].want);
        drain_results();

        // Strong wind, then the remaining directed rows through the predictor.
        write_reg(dts_pkg::CFG_MEAN_WIND, 23'd65535);
        rows.delete();
        r.known = 1'b0;
        r.stim = '{16'sh1000, 16'sh1000, 16'sh1000, 20'd1, 24'sd100, 16'd1};
        rows.push_back(r);   // altitude below the floor
        r.stim = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 20'd1048575, 24'sd256, 16'd65535};
        rows.push_back(r);   // rates saturate, gusts near full scale
        r.stim = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 20'd1048575, 24'sd256, 16'd65535};
        rows.push_back(r);
        r.stim = '{-16'sh8000, -16'sh8000, -16'sh8000, 20'd1048575, -24'sd5, 16'd65535};
        rows.push_back(r);   // negative altitude, swing to the other extreme
        r.stim = '{16'sh0, 16'sh0, 16'sh0, 20'd5000, 24'sd1000, 16'd0};
        rows.push_back(r);   // zero speed holds the states
        r.stim = '{16'sh0aaa, -16'sh5555, 16'sh2aaa, 20'd699050, 24'sd8388607, 16'd43690};
        rows.push_back(r);   // top altitude
        r.stim = '{-16'sh2000, 16'sh3000, -16'sh0100, 20'd349525, 24'sh555555, 16'd21845};
        rows.push_back(r);
        foreach (rows[i]) send_step(rows[i].stim, rows[i].known, rows[i].want);
        drain_results();

        // A floor of zero acts as one.
        write_reg(dts_pkg::CFG_MIN_ALT, 23'd0);
        send_step('{16'sh1000, -16'sh1000, 16'sh0800, 20'd1, 24'sd0, 16'd1}, 1'b0, zero_g);
        send_step('{16'sh1000, -16'sh1000, 16'sh0800, 20'd2000, -24'sd1, 16'd200}, 1'b0, zero_g);
        drain_results();
        write_reg(dts_pkg::CFG_MIN_ALT, 23'd8388607);
        send_step('{16'sh1000, -16'sh1000, 16'sh0800, 20'd2000, 24'sd12, 16'd200}, 1'b0, zero_g);
        drain_results();

        // Random part in four phases with their own gap, stall and wind settings.
        wind_set = '{23'd0, 23'd65535, 23'd2560, 23'($urandom_range(65535))};
        alt_set  = '{23'd1, 23'd256, 23'd8388607, 23'($urandom_range(2560, 1))};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 49 : (ph == 3) ? 18 : 0;
            recv_stall_pct = (ph == 2) ? 49 : (ph == 3) ? 18 : 0;
            write_reg(dts_pkg::CFG_MEAN_WIND, wind_set[ph]);
            write_reg(dts_pkg::CFG_MIN_ALT, (ph == 2) ? alt_set[1] : alt_set[ph]);
            for (int n = 0; n < 225; n++) begin
                st = rand_step();
                send_step(st, 1'b0, zero_g);
            end
            drain_results();
        end
        if (ph_ok()) begin
            $display("[dryden_turbulence_step] OK");
        end else begin
            $display("[dryden_turbulence_step] ERROR");
        end
        $finish;
    end

endmodule
